/* design/wma_pkg.sv */
// Shared constants and types for the warm-up moving average filter.
package wma_pkg;

  // Fixed width of one speed sample and of one mean
  localparam int unsigned SampleW = 16;

  // Execution sequencer states, one-hot
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StRead = 4'b0010,
    StDiv  = 4'b0100,
    StDone = 4'b1000
  } back_state_e;

endpackage

/* design/warmup_moving_average.sv */
// A transferred sample waits in the two-entry queue; the back end then reads its ring slot,
// updates the running sum, divides and registers the mean on mean_o.
// The back end takes a new sample only from idle, after its last mean has been registered, so
// the one-bit-per-cycle restoring divider sets throughput; a two-entry queue absorbs bursts.
// Reset clears the slot pointer, fill count, running sum and all handshake state at once;
// ring slots are never cleared, since a slot's old value is ignored until it has been written.
module warmup_moving_average #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               sample_valid_i,
  output logic                               sample_stall_o,
  input  logic signed [wma_pkg::SampleW-1:0] sample_i,
  output logic                               mean_valid_o,
  input  logic                               mean_stall_i,
  output logic signed [wma_pkg::SampleW-1:0] mean_o
);
  import wma_pkg::*;

  localparam int unsigned PosW   = $clog2(WINDOW);
  localparam int unsigned CntW   = $clog2(WINDOW + 1);
  localparam int unsigned EntryW = SampleW + PosW + 1 + CntW;

  logic                push_valid, push_stall;
  logic [SampleW-1:0]  push_sample;
  logic [PosW-1:0]     push_pos;
  logic                push_replace;
  logic [CntW-1:0]     push_divisor;
  logic                q_valid, q_stall;
  logic [EntryW-1:0]   q_data;

  wma_front #(
    .Window (WINDOW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .sample_i       (sample_i),
    .push_valid_o   (push_valid),
    .push_stall_i   (push_stall),
    .push_sample_o  (push_sample),
    .push_pos_o     (push_pos),
    .push_replace_o (push_replace),
    .push_divisor_o (push_divisor)
  );

  wma_fifo #(
    .Width (EntryW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push_valid),
    .in_stall_o  (push_stall),
    .in_data_i   ({push_sample, push_pos, push_replace, push_divisor}),
    .out_valid_o (q_valid),
    .out_stall_i (q_stall),
    .out_data_o  (q_data)
  );

  wma_back #(
    .Window (WINDOW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_stall_o    (q_stall),
    .q_sample_i   (q_data[EntryW-1 -: SampleW]),
    .q_pos_i      (q_data[CntW+1 +: PosW]),
    .q_replace_i  (q_data[CntW]),
    .q_divisor_i  (q_data[CntW-1:0]),
    .mean_valid_o (mean_valid_o),
    .mean_stall_i (mean_stall_i),
    .mean_o       (mean_o)
  );

endmodule

/* design/wma_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module wma_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/wma_fifo.sv */
// Two-entry queue between the classifying front and the executing back.
module wma_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [Width-1:0] out_data_o
);

  logic [Width-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push, pop;

  assign in_stall_o  = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = entry_q[rd_ptr_q];

  assign push = in_valid_i && !in_stall_o;
  assign pop  = out_valid_o && !out_stall_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

/* design/wma_front.sv */
// Front end: accepts samples and tags each with its ring slot and divisor.
module wma_front #(
  parameter int unsigned Window = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               sample_valid_i,
  output logic                               sample_stall_o,
  input  logic signed [wma_pkg::SampleW-1:0] sample_i,
  output logic                               push_valid_o,
  input  logic                               push_stall_i,
  output logic        [wma_pkg::SampleW-1:0] push_sample_o,
  output logic        [$clog2(Window)-1:0]   push_pos_o,
  output logic                               push_replace_o,
  output logic        [$clog2(Window+1)-1:0] push_divisor_o
);
  import wma_pkg::*;

  localparam int unsigned PosW = $clog2(Window);
  localparam int unsigned CntW = $clog2(Window + 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            full;
  logic            xfer;

  assign full = (fill_q == CntW'(Window));
  assign xfer = sample_valid_i && !sample_stall_o;

  // Pass the transfer straight on to the queue
  assign push_valid_o   = sample_valid_i;
  assign sample_stall_o = push_stall_i;
  assign push_sample_o  = sample_i;
  assign push_pos_o     = pos_q;
  assign push_replace_o = full;
  assign push_divisor_o = full ? fill_q : fill_q + CntW'(1);

  // Advance the slot pointer and the saturating fill count
  always_comb begin
    pos_d  = pos_q;
    fill_d = fill_q;
    if (xfer) begin
      pos_d = (pos_q == PosW'(Window - 1)) ? '0 : pos_q + PosW'(1);
      if (!full) begin
        fill_d = fill_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fill_q <= '0;
    end else begin
      pos_q  <= pos_d;
      fill_q <= fill_d;
    end
  end

endmodule

/* design/wma_back.sv */
// Back end: updates the ring and running sum, then divides bit by bit.
module wma_back #(
  parameter int unsigned Window = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  output logic                               q_stall_o,
  input  logic        [wma_pkg::SampleW-1:0] q_sample_i,
  input  logic        [$clog2(Window)-1:0]   q_pos_i,
  input  logic                               q_replace_i,
  input  logic        [$clog2(Window+1)-1:0] q_divisor_i,
  output logic                               mean_valid_o,
  input  logic                               mean_stall_i,
  output logic signed [wma_pkg::SampleW-1:0] mean_o
);
  import wma_pkg::*;

  localparam int unsigned PosW  = $clog2(Window);
  localparam int unsigned CntW  = $clog2(Window + 1);
  localparam int unsigned SumW  = SampleW + $clog2(Window);
  localparam int unsigned StepW = $clog2(SumW);

  back_state_e state_q, state_d;

  logic        [SampleW-1:0] sample_q;
  logic        [PosW-1:0]    pos_q;
  logic                      replace_q;
  logic        [CntW-1:0]    div_q;
  logic signed [SumW-1:0]    sum_q, sum_d;
  logic        [SumW-1:0]    dq_q, dq_d;
  logic        [CntW-1:0]    rem_q, rem_d;
  logic        [StepW-1:0]   step_q, step_d;
  logic                      neg_q, neg_d;
  logic                      out_valid_q, out_valid_d;
  logic        [SampleW-1:0] out_q, out_d;

  logic                      pop;
  logic        [SampleW-1:0] ram_rdata;
  logic signed [SampleW-1:0] old_val;
  logic signed [SampleW-1:0] new_val;
  logic                      ram_we;
  logic        [CntW:0]      trial;
  logic                      ge;
  logic        [SumW-1:0]    mag;
  logic        [SumW-1:0]    quot_s;
  logic                      out_free;

  wma_ram #(
    .Width (SampleW),
    .Depth (Window)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (sample_q),
    .re_i    (pop),
    .raddr_i (q_pos_i),
    .rdata_o (ram_rdata)
  );

  assign q_stall_o = (state_q != StIdle);
  assign pop       = q_valid_i && (state_q == StIdle);
  assign ram_we    = (state_q == StRead);

  // Slots not yet filled since reset count as zero
  assign old_val = replace_q ? $signed(ram_rdata) : '0;
  assign new_val = $signed(sample_q);
  assign sum_d   = (state_q == StRead)
                 ? sum_q - SumW'(old_val) + SumW'(new_val) : sum_q;
  assign mag     = sum_d[SumW-1] ? (~sum_d) + SumW'(1) : sum_d;

  // One restoring divide step
  assign trial = {rem_q, dq_q[SumW-1]};
  assign ge    = (trial >= {1'b0, div_q});

  // Apply the sign to the quotient magnitude
  assign quot_s   = neg_q ? (~dq_q) + SumW'(1) : dq_q;
  assign out_free = !out_valid_q || !mean_stall_i;

  always_comb begin
    state_d     = state_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    step_d      = step_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && mean_stall_i;
    out_d       = out_q;
    unique case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          state_d = StRead;
        end
      end
      StRead: begin
        neg_d   = sum_d[SumW-1];
        dq_d    = mag;
        rem_d   = '0;
        step_d  = StepW'(SumW - 1);
        state_d = StDiv;
      end
      StDiv: begin
        dq_d  = {dq_q[SumW-2:0], ge};
        rem_d = ge ? CntW'(trial - {1'b0, div_q}) : trial[CntW-1:0];
        if (step_q == '0) begin
          state_d = StDone;
        end else begin
          step_d = step_q - StepW'(1);
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = quot_s[SampleW-1:0];
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold item fields and divider datapath
  always_ff @(posedge clk_i) begin
    if (pop) begin
      sample_q  <= q_sample_i;
      pos_q     <= q_pos_i;
      replace_q <= q_replace_i;
      div_q     <= q_divisor_i;
    end
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    neg_q  <= neg_d;
    out_q  <= out_d;
  end

  assign mean_valid_o = out_valid_q;
  assign mean_o       = $signed(out_q);

endmodule

/* tb/warmup_moving_average_checker.sv */
// Scoreboard for the warm-up moving average: predicts each mean and compares it on transfer.
`timescale 1ns / 100ps

module warmup_moving_average_checker #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               sample_valid_i,
  input  logic                               sample_stall_i,
  input  logic signed [wma_pkg::SampleW-1:0] sample_i,
  input  logic                               mean_valid_i,
  input  logic                               mean_stall_i,
  input  logic signed [wma_pkg::SampleW-1:0] mean_i,
  output int unsigned                        fail_count_o,
  output int unsigned                        pending_o
);

  typedef logic signed [wma_pkg::SampleW-1:0] speed_t;

  // Shadow copy of the filter window
  speed_t      window_ring [WINDOW];
  int unsigned ring_slot;
  int unsigned ring_fill;
  int signed   ring_sum;

  speed_t      expected_means [$];
  int unsigned mismatches;

  assign fail_count_o = mismatches;

  // Insert one sample into the shadow window and return the mean it yields
  function automatic speed_t predict_mean(input speed_t s);
    int signed quotient;
    ring_sum = ring_sum - int'(window_ring[ring_slot]) + int'(s);
    window_ring[ring_slot] = s;
    ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
    if (ring_fill < WINDOW) ring_fill++;
    // SystemVerilog integer divide truncates toward zero
    quotient = ring_sum / int'(ring_fill);
    return speed_t'(quotient);
  endfunction

  // Track transfers on both channels
  always @(posedge clk_i or negedge rst_ni) begin
    speed_t want;
    if (!rst_ni) begin
      foreach (window_ring[i]) window_ring[i] = '0;
      ring_slot = 0;
      ring_fill = 0;
      ring_sum = 0;
      expected_means.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      // Compare the output transfer with the oldest prediction
      if (mean_valid_i && !mean_stall_i) begin
        if (expected_means.size() == 0) begin
          $error("mean: unexpected transfer, actual %0d", mean_i);
          mismatches++;
        end else begin
          want = expected_means.pop_front();
          if (mean_i !== want) begin
            $error("mean: expected %0d, actual %0d", want, mean_i);
            mismatches++;
          end
        end
      end
      // Predict the result of each input transfer
      if (sample_valid_i && !sample_stall_i) expected_means.push_back(predict_mean(sample_i));
      pending_o <= expected_means.size();
    end
  end

endmodule

/* tb/warmup_moving_average_tb.sv */
// Stimulus, clocking and verdict for the warm-up moving average filter.
`timescale 1ns / 100ps

module warmup_moving_average_tb;

  localparam int unsigned WINDOW       = 10;
  localparam int unsigned RandomItems  = 800;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned DrainCycles  = 60;

  typedef logic signed [wma_pkg::SampleW-1:0] speed_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  speed_t      sample = '0;
  logic        mean_valid;
  logic        mean_stall = 1'b0;
  speed_t      mean;
  int unsigned fail_count;
  int unsigned pending_means;
  int unsigned cycle_count = 0;

  always #5 clk_i = ~clk_i;

  warmup_moving_average #(
    .WINDOW(WINDOW)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_valid_i(sample_valid),
    .sample_stall_o(sample_stall),
    .sample_i      (sample),
    .mean_valid_o  (mean_valid),
    .mean_stall_i  (mean_stall),
    .mean_o        (mean)
  );

  warmup_moving_average_checker #(
    .WINDOW(WINDOW)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_valid_i(sample_valid),
    .sample_stall_i(sample_stall),
    .sample_i      (sample),
    .mean_valid_i  (mean_valid),
    .mean_stall_i  (mean_stall),
    .mean_i        (mean),
    .fail_count_o  (fail_count),
    .pending_o     (pending_means)
  );

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stall the output now and then, except during a quiet stretch
  always @(posedge clk_i) begin
    if (cycle_count >= 4000 && cycle_count < 9000) mean_stall <= 1'b0;
    else mean_stall <= ($urandom_range(99) < 6);
  end

  // Offer one sample, with optional random idle cycles, and hold it until the transfer
  task automatic send_sample(input speed_t s, input bit may_idle);
    while (may_idle && $urandom_range(99) < 6) begin
      sample_valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_valid <= 1'b1;
    sample <= s;
    @(posedge clk_i);
    while (sample_stall) @(posedge clk_i);
  endtask

  // Hold the input until every predicted mean has come out
  task automatic drain_means();
    sample_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_means != 0) @(posedge clk_i);
  endtask

  // Draw a random sample: full range mostly, with extremes and small values mixed in
  function automatic speed_t random_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return speed_t'($urandom_range(65535));
    if (pick < 75) begin
      case ($urandom_range(4))
        0:       return 16'sh7fff;
        1:       return 16'sh8000;
        2:       return -16'sd1;
        3:       return 16'sd1;
        default: return 16'sd0;
      endcase
    end
    return speed_t'(int'($urandom_range(200)) - 100);
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First sample at the negative extreme, then a pair whose mean truncates to zero
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7fff, 1'b1);
    // Fill the whole window with each extreme so the pointer wraps and the sum peaks
    repeat (WINDOW) send_sample(16'sh7fff, 1'b1);
    repeat (WINDOW) send_sample(16'sh8000, 1'b1);
    send_sample(16'sh5555, 1'b1);
    send_sample(16'shaaaa, 1'b1);
    send_sample(-16'sd1, 1'b1);
    drain_means();

    // Random samples, with a burst that never idles and a full drain midway
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) drain_means();
      send_sample(random_sample(), !(n >= 150 && n < 330));
    end

    // Wait for the last means, then let the pipeline settle
    drain_means();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_means == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
design/wma_pkg.sv
design/wma_ram.sv
design/wma_fifo.sv
design/wma_front.sv
design/wma_back.sv
design/warmup_moving_average.sv
tb/warmup_moving_average_checker.sv
tb/warmup_moving_average_tb.sv
